@@ src/iws_pkg.sv @@
// shared constants, codes and control/status bundles for the indexed word stack
package iws_pkg;

   localparam int DEPTH_DEF   = 1024;
   localparam int WORD_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int BYTE_IDX_W  = 3;
   localparam int CMD_W       = 3;
   localparam int POS_W       = 13;
   localparam int STATUS_W    = 2;
   localparam int CAP_W       = 11;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CAP_W-1:0]      CAP_RESET = 11'd1024;
   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 3'd7;

   // register index within the csr space
   localparam logic REG_CAPACITY = 1'b0;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RDW  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRW  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RDB  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WRB  = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // memory address source
   localparam logic [1:0] ASEL_COUNT = 2'd0;
   localparam logic [1:0] ASEL_TOP   = 2'd1;
   localparam logic [1:0] ASEL_POS   = 2'd2;
   localparam logic [1:0] ASEL_FRAME = 2'd3;

   // memory write data source
   localparam logic [1:0] WSEL_VALUE = 2'd0;
   localparam logic [1:0] WSEL_ZERO  = 2'd1;
   localparam logic [1:0] WSEL_MERGE = 2'd2;

   typedef struct packed {
      logic                load_req;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                mem_we;
      logic                mem_re;
      logic [1:0]          addr_sel;
      logic [1:0]          wdata_sel;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                rsp_load;
      logic                rsp_word;
      logic                rsp_byte;
   } ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             is_full;
      logic             is_empty;
      logic             pos_oor;
      logic             frame_oor;
      logic             frame_past_lim;
      logic             fill_go;
      logic             status_ok;
      logic             rsp_free;
   } stat_type;

endpackage

@@ src/iws_ram.sv @@
// generic single-port-write ram with registered read
module iws_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

@@ src/iws_csr.sv @@
// capacity register behind the apb-style configuration port
module iws_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [iws_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iws_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iws_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [iws_pkg::CAP_W-1:0]        capacity
);
   import iws_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             hit_cap;

   assign hit_cap = (csr_paddr[CSR_ADDR_W-1] == REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit_cap) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit_cap ? CSR_DATA_W'(cap_ff) : '0;
   assign capacity   = cap_ff;

endmodule

@@ src/iws_ctrl.sv @@
// command sequencer for the indexed word stack
module iws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iws_pkg::stat_type stat,
   output iws_pkg::ctrl_type ctrl
);
   import iws_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.set_status  = 1'b1;
            ctrl.status_code = ST_OK;
            state_in         = S_DONE;
            case (stat.cmd)
               CMD_PUSH: begin
                  if (stat.is_full) begin
                     ctrl.status_code = ST_FULL;
                  end else begin
                     ctrl.mem_we    = 1'b1;
                     ctrl.addr_sel  = ASEL_COUNT;
                     ctrl.wdata_sel = WSEL_VALUE;
                     ctrl.cnt_inc   = 1'b1;
                  end
               end
               CMD_POP: begin
                  if (stat.is_empty) begin
                     ctrl.status_code = ST_EMPTY;
                  end else begin
                     ctrl.mem_re   = 1'b1;
                     ctrl.addr_sel = ASEL_TOP;
                     ctrl.cnt_dec  = 1'b1;
                  end
               end
               CMD_RDW: begin
                  if (stat.pos_oor) begin
                     ctrl.status_code = ST_RANGE;
                  end else begin
                     ctrl.mem_re   = 1'b1;
                     ctrl.addr_sel = ASEL_POS;
                  end
               end
               CMD_WRW: begin
                  if (stat.pos_oor) begin
                     ctrl.status_code = ST_RANGE;
                  end else begin
                     ctrl.mem_we    = 1'b1;
                     ctrl.addr_sel  = ASEL_POS;
                     ctrl.wdata_sel = WSEL_VALUE;
                  end
               end
               CMD_RDB: begin
                  if (stat.frame_oor) begin
                     ctrl.status_code = ST_RANGE;
                  end else begin
                     ctrl.mem_re   = 1'b1;
                     ctrl.addr_sel = ASEL_FRAME;
                  end
               end
               CMD_WRB: begin
                  if (stat.frame_past_lim) begin
                     ctrl.status_code = ST_RANGE;
                  end else begin
                     state_in = S_FILL;
                  end
               end
               default: begin
               end
            endcase
         end
         S_FILL: begin
            if (stat.fill_go) begin
               ctrl.mem_we    = 1'b1;
               ctrl.addr_sel  = ASEL_COUNT;
               ctrl.wdata_sel = WSEL_ZERO;
               ctrl.cnt_inc   = 1'b1;
            end else if (stat.frame_oor) begin
               ctrl.set_status  = 1'b1;
               ctrl.status_code = ST_FULL;
               state_in         = S_DONE;
            end else begin
               ctrl.mem_re   = 1'b1;
               ctrl.addr_sel = ASEL_FRAME;
               state_in      = S_MERGE;
            end
         end
         S_MERGE: begin
            ctrl.mem_we    = 1'b1;
            ctrl.addr_sel  = ASEL_FRAME;
            ctrl.wdata_sel = WSEL_MERGE;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               ctrl.rsp_load = 1'b1;
               ctrl.rsp_word = stat.status_ok && (stat.cmd inside {CMD_POP, CMD_RDW});
               ctrl.rsp_byte = stat.status_ok && (stat.cmd == CMD_RDB);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/iws_dpath.sv @@
// datapath: command registers, word count, word store and result register
module iws_dpath #(
   parameter int DEPTH = iws_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [iws_pkg::CMD_W-1:0]           req_cmd,
   input  logic [iws_pkg::POS_W-1:0]           req_position,
   input  logic signed [iws_pkg::WORD_W-1:0]   req_value,
   input  logic [iws_pkg::BYTE_W-1:0]          req_byte_data,
   input  logic [iws_pkg::CAP_W-1:0]           capacity,
   input  iws_pkg::ctrl_type                   ctrl,
   output iws_pkg::stat_type                   stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [iws_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [iws_pkg::WORD_W-1:0]   rsp_read_word,
   output logic [iws_pkg::BYTE_W-1:0]          rsp_read_byte,
   output logic [CNT_W-1:0]                    rsp_fill_count,
   output logic                                rsp_is_empty
);
   import iws_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CMD_W-1:0]    cmd_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [WORD_W-1:0]   val_ff;
   logic [BYTE_W-1:0]   bdat_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_empty_ff;

   logic [CMP_W-1:0]      count_ext;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      frame_ext;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      depth_ext;
   logic [CMP_W-1:0]      lim_ext;
   logic [CNT_W-1:0]      count_m1;
   logic [ADDR_W-1:0]     mem_addr;
   logic [WORD_W-1:0]     mem_wdata;
   logic [WORD_W-1:0]     mem_rdata;
   logic [WORD_W-1:0]     merged;
   logic [BYTE_IDX_W-1:0] lane;
   logic [BYTE_W-1:0]     lane_byte;

   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign frame_ext = CMP_W'(pos_ff >> BYTE_IDX_W);
   assign cap_ext   = CMP_W'(capacity);
   assign depth_ext = CMP_W'(DEPTH);
   assign lim_ext   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
   assign count_m1  = count_ff - 1'b1;

   // byte 0 is the most significant byte of the word
   assign lane      = LAST_BYTE - pos_ff[BYTE_IDX_W-1:0];
   assign lane_byte = mem_rdata[lane*BYTE_W +: BYTE_W];

   always_comb begin
      merged = mem_rdata;
      merged[lane*BYTE_W +: BYTE_W] = bdat_ff;
   end

   always_comb begin
      case (ctrl.addr_sel)
         ASEL_COUNT: mem_addr = count_ff[ADDR_W-1:0];
         ASEL_TOP:   mem_addr = count_m1[ADDR_W-1:0];
         ASEL_POS:   mem_addr = pos_ext[ADDR_W-1:0];
         ASEL_FRAME: mem_addr = frame_ext[ADDR_W-1:0];
         default:    mem_addr = count_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      case (ctrl.wdata_sel)
         WSEL_VALUE: mem_wdata = val_ff;
         WSEL_ZERO:  mem_wdata = '0;
         WSEL_MERGE: mem_wdata = merged;
         default:    mem_wdata = '0;
      endcase
   end

   iws_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ctrl.mem_we),
      .waddr (mem_addr),
      .wdata (mem_wdata),
      .re    (ctrl.mem_re),
      .raddr (mem_addr),
      .rdata (mem_rdata)
   );

   always_comb begin
      count_in = count_ff;
      if (ctrl.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.cnt_dec) begin
         count_in = count_m1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         cmd_ff  <= req_cmd;
         pos_ff  <= req_position;
         val_ff  <= req_value;
         bdat_ff <= req_byte_data;
      end
      if (ctrl.set_status) begin
         status_ff <= ctrl.status_code;
      end
      if (ctrl.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_word_ff   <= ctrl.rsp_word ? mem_rdata : '0;
         rsp_byte_ff   <= ctrl.rsp_byte ? lane_byte : '0;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   always_comb begin
      stat.cmd            = cmd_ff;
      stat.is_full        = (count_ext >= lim_ext);
      stat.is_empty       = (count_ff == '0);
      stat.pos_oor        = (pos_ext >= count_ext);
      stat.frame_oor      = (frame_ext >= count_ext);
      stat.frame_past_lim = (frame_ext > lim_ext);
      stat.fill_go        = (count_ext <= frame_ext) && (count_ext < lim_ext);
      stat.status_ok      = (status_ff == ST_OK);
      stat.rsp_free       = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_fill_count = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

@@ src/indexed_word_stack.sv @@
// top level of the indexed word stack: csr block, sequencer and datapath
//
// A LIFO of 64-bit signed words that can also be reached by word index and by
// byte address (byte 0 is the most significant byte of a word). One request
// beat gives one response beat carrying status, read word, read byte, fill
// count and an empty flag. Requests are handled one at a time: a plain
// command steps from request beat to response beat through accept, execute
// on the single-port word store and load of the response register, the
// store's registered read landing just as the response is loaded. A byte
// write first pushes zero words one by one to grow the stack, then reads,
// merges and writes back the addressed word, or ends with full status when
// growth stops at the limit. The response register holds a finished beat
// while the consumer stalls; a further request is accepted meanwhile but only
// completes once the held beat is taken. The store needs no clearing pass:
// the word count guards every read. The capacity register (byte address 0)
// limits the stack to min(capacity, DEPTH) words and should be written only
// while the block is idle.
module indexed_word_stack #(
   parameter int DEPTH = iws_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [iws_pkg::CMD_W-1:0]           req_cmd,
   input  logic [iws_pkg::POS_W-1:0]           req_position,
   input  logic signed [iws_pkg::WORD_W-1:0]   req_value,
   input  logic [iws_pkg::BYTE_W-1:0]          req_byte_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [iws_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [iws_pkg::WORD_W-1:0]   rsp_read_word,
   output logic [iws_pkg::BYTE_W-1:0]          rsp_read_byte,
   output logic [CNT_W-1:0]                    rsp_fill_count,
   output logic                                rsp_is_empty,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [iws_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [iws_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [iws_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import iws_pkg::*;

   // word limit as programmed, clamped inside the datapath
   logic [CAP_W-1:0] capacity;

   // command and status bundles between sequencer and datapath
   ctrl_type ctrl;
   stat_type stat;

   iws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   // sequencer: one request at a time, zero-fill loop for growing byte writes
   iws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // datapath: captured request, word count, word store, response register
   iws_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_byte_data  (req_byte_data),
      .capacity       (capacity),
      .ctrl           (ctrl),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_word  (rsp_read_word),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty)
   );

endmodule

@@ src/iws_checker.sv @@
// port-level assertions for the indexed word stack and their bind
module iws_checker #(
   parameter int DEPTH = iws_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [iws_pkg::STATUS_W-1:0]        rsp_status,
   input logic signed [iws_pkg::WORD_W-1:0]   rsp_read_word,
   input logic [iws_pkg::BYTE_W-1:0]          rsp_read_byte,
   input logic [CNT_W-1:0]                    rsp_fill_count,
   input logic                                rsp_is_empty
);
   import iws_pkg::*;

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_word)
         && $stable(rsp_status) && $stable(rsp_fill_count))
      else $error("stalled response beat changed");

   // empty flag agrees with the fill count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("empty flag disagrees with fill count");

   // failed commands return no data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_word == '0) && (rsp_read_byte == '0))
      else $error("read data on a failed command");

   // word and byte data never come back on the same beat
   a_one_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_byte != '0) |-> (rsp_read_word == '0))
      else $error("word and byte data on one beat");

endmodule

bind indexed_word_stack iws_checker #(.DEPTH(DEPTH)) u_iws_checker (.*);

@@ verif/indexed_word_stack_test.sv @@
// self-checking testbench for the indexed word stack: mirror, checker and drivers
module indexed_word_stack_test;
   import iws_pkg::*;

   localparam int CNT_W          = $clog2(DEPTH_DEF + 1);
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int TAIL_CYCLES    = 20;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_MAX     = 10;
   localparam int HOLD_CYCLES    = 300;
   localparam int LAST_FRAME     = (1 << (POS_W - BYTE_IDX_W)) - 1;

   // codes outside the command set, the block ignores them
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   localparam logic [WORD_W-1:0] WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [WORD_W-1:0] WORD_ONES = '1;
   localparam logic [POS_W-1:0]  POS_LAST  = '1;

   // one response beat, field by field
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   word;
      logic [BYTE_W-1:0]   rbyte;
      logic [CNT_W-1:0]    fill;
      logic                empty;
   } stack_rsp_type;

   // mirror of the stack contents plus the queue of responses still owed
   class stack_mirror_type;
      logic [WORD_W-1:0] words [DEPTH_DEF];
      int unsigned       count;
      int unsigned       capacity;
      stack_rsp_type     expected_rsps [$];
      int                errors;

      function new();
         count    = 0;
         capacity = CAP_RESET;
         errors   = 0;
      endfunction

      function int unsigned limit();
         return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= REPORT_MAX) $display("mismatch: %s", what);
      endfunction

      // work out the response of one accepted request beat
      function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                 logic [WORD_W-1:0] val, logic [BYTE_W-1:0] bd);
         stack_rsp_type r;
         int unsigned   lim;
         int unsigned   frame;
         int unsigned   shift;
         lim   = limit();
         frame = pos >> BYTE_IDX_W;
         shift = (LAST_BYTE - pos[BYTE_IDX_W-1:0]) * BYTE_W;
         r     = '0;
         r.status = ST_OK;
         case (cmd)
            CMD_PUSH: begin
               if (count >= lim) r.status = ST_FULL;
               else begin
                  words[count] = val;
                  count++;
               end
            end
            CMD_POP: begin
               if (count == 0) r.status = ST_EMPTY;
               else begin
                  count--;
                  r.word = words[count];
               end
            end
            CMD_RDW: begin
               if (pos >= count) r.status = ST_RANGE;
               else r.word = words[pos];
            end
            CMD_WRW: begin
               if (pos >= count) r.status = ST_RANGE;
               else words[pos] = val;
            end
            CMD_RDB: begin
               if (frame >= count) r.status = ST_RANGE;
               else r.rbyte = words[frame][shift +: BYTE_W];
            end
            CMD_WRB: begin
               if (frame > lim) r.status = ST_RANGE;
               else begin
                  // grow with zero words up to the addressed one or the limit
                  while (count <= frame && count < lim) begin
                     words[count] = '0;
                     count++;
                  end
                  if (frame >= count) r.status = ST_FULL;
                  else words[frame][shift +: BYTE_W] = bd;
               end
            end
            default: ;
         endcase
         r.fill  = CNT_W'(count);
         r.empty = (count == 0);
         expected_rsps.push_back(r);
      endfunction

      function void check_response(stack_rsp_type got);
         stack_rsp_type want;
         if (expected_rsps.size() == 0) begin
            flag($sformatf("response beat with none owed: %p", got));
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status)
            flag($sformatf("status exp %0d got %0d", want.status, got.status));
         if (got.word !== want.word)
            flag($sformatf("read_word exp %h got %h", want.word, got.word));
         if (got.rbyte !== want.rbyte)
            flag($sformatf("read_byte exp %h got %h", want.rbyte, got.rbyte));
         if (got.fill !== want.fill)
            flag($sformatf("fill_count exp %0d got %0d", want.fill, got.fill));
         if (got.empty !== want.empty)
            flag($sformatf("is_empty exp %0b got %0b", want.empty, got.empty));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd       = '0;
   logic [POS_W-1:0]    req_position  = '0;
   logic [WORD_W-1:0]   req_value     = '0;
   logic [BYTE_W-1:0]   req_byte_data = '0;

   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [WORD_W-1:0]   rsp_read_word;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic [CNT_W-1:0]    rsp_fill_count;
   logic                rsp_is_empty;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   stack_mirror_type board = new;

   // idling knobs, in percent per cycle
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   // long receiver hold-off, counted down by the receiver itself
   int unsigned hold_left      = 0;
   int unsigned quiet_cycles   = 0;
   stack_rsp_type seen;

   indexed_word_stack dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_byte_data  (req_byte_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_word  (rsp_read_word),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check each taken beat, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status = rsp_status;
         seen.word   = rsp_read_word;
         seen.rbyte  = rsp_read_byte;
         seen.fill   = rsp_fill_count;
         seen.empty  = rsp_is_empty;
         board.check_response(seen);
      end
      if (hold_left > 0) begin
         // long stall so the block fills up and backs off the request side
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: too long with no beat on any port ends the run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // offer one request beat, with random gaps ahead of it, until it is taken
   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] val, input logic [BYTE_W-1:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_position  <= pos;
      req_value     <= val;
      req_byte_data <= bd;
      do @(posedge clock); while (!req_ready);
      board.note_command(cmd, pos, val, bd);
   endtask

   // sender pauses until every owed response has been taken
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_rsps.size() != 0);
   endtask

   // capacity write while idle, then read it back
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] data);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_CAPACITY, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.capacity = data[CAP_W-1:0];
      // read access straight after the write
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(data[CAP_W-1:0]))
         board.flag($sformatf("capacity readback exp %0d got %0d",
                              data[CAP_W-1:0], csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // pop until the stack holds no more than keep words
   task automatic unwind(input int unsigned keep);
      while (board.count > keep)
         issue_command(CMD_POP, POS_W'($urandom), {$urandom, $urandom}, BYTE_W'($urandom));
   endtask

   // one random request: mostly in-range accesses, some out of range or odd
   task automatic random_command();
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] val;
      logic [BYTE_W-1:0] bd;
      int unsigned       cnt;
      int unsigned       lim;
      int unsigned       frame;
      int unsigned       roll;
      cnt  = board.count;
      lim  = board.limit();
      roll = $urandom_range(99);
      if (roll < 24)      cmd = CMD_PUSH;
      else if (roll < 44) cmd = CMD_POP;
      else if (roll < 56) cmd = CMD_RDW;
      else if (roll < 68) cmd = CMD_WRW;
      else if (roll < 80) cmd = CMD_RDB;
      else if (roll < 95) cmd = CMD_WRB;
      else                cmd = roll[0] ? CMD_SPARE_A : CMD_SPARE_B;

      pos  = POS_W'($urandom);
      roll = $urandom_range(99);
      case (cmd)
         CMD_RDW, CMD_WRW: begin
            if (cnt > 0 && roll < 85) pos = POS_W'($urandom_range(cnt - 1));
            else if (roll < 93)       pos = POS_W'(cnt + $urandom_range(2));
         end
         CMD_RDB: begin
            if (cnt > 0 && roll < 85) pos = POS_W'($urandom_range(8 * cnt - 1));
            else if (roll < 93)       pos = POS_W'(8 * cnt + $urandom_range(15));
         end
         CMD_WRB: begin
            // growth stays small except for the rare whole-range frame
            frame = $urandom_range(LAST_FRAME);
            if (cnt > 0 && roll < 55) frame = $urandom_range(cnt - 1);
            else if (roll < 82)       frame = cnt + $urandom_range(3);
            else if (roll < 90)       frame = lim;
            else if (roll < 98)       frame = lim + 1 + $urandom_range(3);
            if (frame > LAST_FRAME) frame = LAST_FRAME;
            pos = {frame[POS_W-BYTE_IDX_W-1:0], BYTE_IDX_W'($urandom)};
         end
         default: ;
      endcase

      roll = $urandom_range(99);
      case (roll % 10)
         0:       val = WORD_MAX;
         1:       val = WORD_MIN;
         2:       val = WORD_ONES;
         3:       val = '0;
         default: val = {$urandom, $urandom};
      endcase
      if (roll >= 10) val = {$urandom, $urandom};
      bd = BYTE_W'($urandom);
      issue_command(cmd, pos, val, bd);
   endtask

   // a phase of random traffic under one idling mode, optional hold-off midway
   task automatic run_random(input int n, input int unsigned sidle, input int unsigned rstall,
                             input int hold_at);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      for (int i = 0; i < n; i++) begin
         if (i == hold_at) hold_left = HOLD_CYCLES;
         random_command();
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-stack errors, byte order, extremes, ignored codes
      issue_command(CMD_POP, '0, '0, '0);
      issue_command(CMD_RDW, '0, '0, '0);
      issue_command(CMD_WRW, '0, WORD_ONES, '0);
      issue_command(CMD_RDB, '0, '0, '0);
      // byte write at frame zero on an empty stack grows one word
      issue_command(CMD_WRB, 13'd3, '0, 8'hA5);
      issue_command(CMD_PUSH, '0, WORD_MAX, '0);
      issue_command(CMD_PUSH, '0, WORD_MIN, '0);
      issue_command(CMD_PUSH, '0, WORD_ONES, '0);
      // most and least significant byte of a word
      issue_command(CMD_RDB, 13'd8, '0, '0);
      issue_command(CMD_RDB, 13'd15, '0, '0);
      issue_command(CMD_WRB, 13'd23, '0, 8'h00);
      issue_command(CMD_WRW, 13'd3, 64'h0123_4567_89AB_CDEF, '0);
      issue_command(CMD_RDW, 13'd3, '0, '0);
      issue_command(CMD_RDW, 13'd4, '0, '0);
      issue_command(CMD_RDW, POS_LAST, '0, '0);
      issue_command(CMD_RDB, POS_LAST, '0, '0);
      issue_command(CMD_SPARE_A, POS_LAST, WORD_ONES, 8'hFF);
      issue_command(CMD_SPARE_B, '0, WORD_MAX, 8'h5A);
      issue_command(CMD_POP, '0, '0, '0);
      issue_command(CMD_POP, '0, '0, '0);
      drain();

      // capacity sweep, each phase under its own idling mode
      write_capacity(CSR_DATA_W'(CAP_RESET));
      run_random(250, 0, 0, -1);

      write_capacity(32'd16);
      unwind(18);
      run_random(250, 0, 79, -1);

      write_capacity(32'd1);
      unwind(3);
      run_random(150, 79, 0, -1);

      // zero capacity: every push fails
      write_capacity(32'd0);
      unwind(2);
      run_random(100, 24, 24, -1);

      // out-of-range capacity clamps to the store depth; receiver hold-off midway
      write_capacity(32'hFFFF_FFFF);
      run_random(250, 0, 0, 120);

      // capacity lowered under the current fill: held words stay reachable
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (12) issue_command(CMD_PUSH, '0, {$urandom, $urandom}, '0);
      write_capacity(32'd3);
      run_random(150, 79, 0, -1);

      write_capacity(32'd8);
      unwind(10);
      run_random(250, 24, 24, -1);

      // full depth: one byte write at the last address fills the whole store
      write_capacity(CSR_DATA_W'(CAP_RESET));
      issue_command(CMD_WRB, POS_LAST, '0, 8'hFF);
      issue_command(CMD_PUSH, '0, WORD_MAX, '0);
      issue_command(CMD_RDB, POS_LAST, '0, '0);
      issue_command(CMD_POP, '0, '0, '0);
      run_random(450, 0, 79, -1);

      // wind down: wait for every owed beat, then a short tail
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.expected_rsps.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
src/iws_pkg.sv
src/iws_ram.sv
src/iws_csr.sv
src/iws_ctrl.sv
src/iws_dpath.sv
src/indexed_word_stack.sv
src/iws_checker.sv
verif/indexed_word_stack_test.sv
